FILE: design/assert_macros.svh
// Assertion macros used by the factorizer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/fces_pkg.sv
// Package with field widths and the triangular step function of the factorizer.
`timescale 1ns / 1ps
`default_nettype none

package fces_pkg;

	localparam int PRIME_W = 32;
	localparam int EXP_W   = 5;
	localparam int STEP_W  = 3;
	localparam int TOTAL_W = 5;

	typedef logic [EXP_W-1:0]  exp_t;
	typedef logic [STEP_W-1:0] step_t;

	// Largest k with k(k+1)/2 not above the exponent.
	function automatic step_t tri_steps(input exp_t e);
		step_t k;
		k = '0;
		if (e >= EXP_W'(1))  k = STEP_W'(1);
		if (e >= EXP_W'(3))  k = STEP_W'(2);
		if (e >= EXP_W'(6))  k = STEP_W'(3);
		if (e >= EXP_W'(10)) k = STEP_W'(4);
		if (e >= EXP_W'(15)) k = STEP_W'(5);
		if (e >= EXP_W'(21)) k = STEP_W'(6);
		if (e >= EXP_W'(28)) k = STEP_W'(7);
		return k;
	endfunction

endpackage

`default_nettype wire

FILE: design/factorize_and_count_exponent_steps.sv
// Trial-division prime factorizer with triangular step count, top level.
//
//   channel   handshake            payload
//   request   start / busy         value
//   result    result_valid strobe  prime, exponent, steps, running_total, last
//
// A request is taken when start is high and busy is low; busy stays high until
// the final result has been issued. Factors of two are stripped at one bit per cycle.
// Each odd trial divisor is run through the shared restoring divider and then checked in
// the evaluation state; values 0 and 1 are answered straight from idle.
// Reset clears the sequencer and the result strobe. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module factorize_and_count_exponent_steps
	import fces_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [31:0]         value,
	output logic                     result_valid,
	output logic [PRIME_W-1:0]       prime,
	output logic [EXP_W-1:0]         exponent,
	output logic [STEP_W-1:0]        steps,
	output logic [TOTAL_W-1:0]       running_total,
	output logic                     last
);

	localparam int CNT_W = $clog2(VALUE_BITS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TWOS  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;
	localparam logic [2:0] S_FINAL = 3'd5;

	logic [2:0]            state_q;
	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] f_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	exp_t                  e_q;
	logic                  chk_q;
	logic                  pend_valid_q;
	logic [PRIME_W-1:0]    pend_prime_q;
	exp_t                  pend_exp_q;
	logic [TOTAL_W-1:0]    total_q;

	logic [VALUE_BITS-1:0] n_in;
	logic [VALUE_BITS:0]   trial;
	logic                  short_en;
	logic                  push_en;
	logic [PRIME_W-1:0]    push_prime;
	exp_t                  push_exp;
	logic                  emit_en;
	logic                  emit_last;
	step_t                 emit_steps;
	logic [TOTAL_W-1:0]    emit_total;

	assign busy     = (state_q != S_IDLE);
	assign n_in     = VALUE_BITS'(value);
	assign trial    = {rem_q, quo_q[VALUE_BITS-1]} - {1'b0, f_q};
	assign short_en = (state_q == S_IDLE) && start && (n_in <= VALUE_BITS'(1));

	always_comb begin
		push_en    = 1'b0;
		push_prime = '0;
		push_exp   = '0;
		unique case (state_q)
			S_TWOS: begin
				if (n_q[0] && (e_q != '0)) begin
					push_en    = 1'b1;
					push_prime = PRIME_W'(2);
					push_exp   = e_q;
				end
			end
			S_EVAL: begin
				if (!chk_q && (rem_q != '0)) begin
					push_en    = 1'b1;
					push_prime = PRIME_W'(f_q);
					push_exp   = e_q;
				end
			end
			S_FLUSH: begin
				if (n_q > VALUE_BITS'(1)) begin
					push_en    = 1'b1;
					push_prime = PRIME_W'(n_q);
					push_exp   = EXP_W'(1);
				end
			end
			default: begin
			end
		endcase
		emit_last  = (state_q == S_FINAL);
		emit_en    = (push_en && pend_valid_q) || emit_last;
		emit_steps = tri_steps(pend_exp_q);
		emit_total = total_q + TOTAL_W'(emit_steps);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			pend_valid_q <= 1'b0;
			chk_q        <= 1'b0;
		end else begin
			result_valid <= emit_en || short_en;
			if (emit_en) begin
				prime         <= pend_prime_q;
				exponent      <= pend_exp_q;
				steps         <= emit_steps;
				running_total <= emit_total;
				last          <= emit_last;
				total_q       <= emit_total;
			end
			if (push_en) begin
				pend_valid_q <= 1'b1;
				pend_prime_q <= push_prime;
				pend_exp_q   <= push_exp;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (n_in <= VALUE_BITS'(1)) begin
							prime         <= '0;
							exponent      <= '0;
							steps         <= '0;
							running_total <= '0;
							last          <= 1'b1;
						end else begin
							n_q          <= n_in;
							e_q          <= '0;
							total_q      <= '0;
							pend_valid_q <= 1'b0;
							state_q      <= S_TWOS;
						end
					end
				end
				S_TWOS: begin
					if (!n_q[0]) begin
						n_q <= n_q >> 1;
						e_q <= e_q + EXP_W'(1);
					end else begin
						e_q     <= '0;
						f_q     <= VALUE_BITS'(3);
						chk_q   <= 1'b1;
						rem_q   <= '0;
						quo_q   <= n_q;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (trial[VALUE_BITS]) begin
						rem_q <= {rem_q[VALUE_BITS-2:0], quo_q[VALUE_BITS-1]};
						quo_q <= {quo_q[VALUE_BITS-2:0], 1'b0};
					end else begin
						rem_q <= trial[VALUE_BITS-1:0];
						quo_q <= {quo_q[VALUE_BITS-2:0], 1'b1};
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (chk_q && (f_q > quo_q)) begin
						state_q <= S_FLUSH;
					end else begin
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
						if (rem_q == '0) begin
							n_q   <= quo_q;
							quo_q <= quo_q;
							chk_q <= 1'b0;
							e_q   <= chk_q ? EXP_W'(1) : e_q + EXP_W'(1);
						end else begin
							quo_q <= n_q;
							f_q   <= f_q + VALUE_BITS'(2);
							chk_q <= 1'b1;
							e_q   <= '0;
						end
					end
				end
				S_FLUSH: begin
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					pend_valid_q <= 1'b0;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_SAME(a_mid_result_busy, clk, arst_n, result_valid && !last, busy,
		"A result that is not the last one appeared while idle.")
	`ASSERT_NEXT(a_start_answered, clk, arst_n, start && !busy,
		busy || (result_valid && last),
		"An accepted request neither started work nor gave its result.")
	`ASSERT_SAME(a_divisor_odd, clk, arst_n, state_q == S_DIV, f_q[0],
		"The trial divisor is even during a division.")
	`ASSERT_SAME(a_final_pending, clk, arst_n, state_q == S_FINAL, pend_valid_q,
		"The final result is missing when the request completes.")

endmodule

`default_nettype wire

FILE: bench/factorize_checker.sv
// Checker that predicts the prime factor results of each request and compares them.
`timescale 1ns / 1ps

module factorize_checker
	import fces_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [31:0]        value,
	input  wire logic               result_valid,
	input  wire logic [PRIME_W-1:0] prime,
	input  wire logic [EXP_W-1:0]   exponent,
	input  wire logic [STEP_W-1:0]  steps,
	input  wire logic [TOTAL_W-1:0] running_total,
	input  wire logic               last,
	output int                      failures,
	output int                      outstanding
);

	localparam int MAX_FACTORS = 9;

	typedef struct packed {
		logic [PRIME_W-1:0] prime;
		exp_t               exponent;
		step_t              steps;
		logic [TOTAL_W-1:0] running_total;
		logic               last;
	} factor_t;

	factor_t expected_factors[$];

	initial begin
		failures = 0;
		outstanding = 0;
	end

	function automatic void push_factor(input logic [31:0] p, input int unsigned mult,
		inout int unsigned total, inout int count);
		factor_t item;
		int unsigned rem;
		int unsigned k;
		int unsigned j;
		if (count >= MAX_FACTORS) return;
		rem = mult;
		k = 0;
		j = 1;
		while (rem >= j) begin
			rem = rem - j;
			k++;
			j++;
		end
		total = total + k;
		item.prime = PRIME_W'(p);
		item.exponent = EXP_W'(mult);
		item.steps = STEP_W'(k);
		item.running_total = TOTAL_W'(total);
		item.last = 1'b0;
		expected_factors.push_back(item);
		count++;
	endfunction

	function automatic void predict_factors(input logic [31:0] request_value);
		logic [31:0] n;
		logic [31:0] f;
		int unsigned mult;
		int unsigned total;
		int count;
		factor_t item;
		n = request_value;
		total = 0;
		count = 0;
		if (n <= 32'd1) begin
			item = '0;
			item.last = 1'b1;
			expected_factors.push_back(item);
			return;
		end
		mult = 0;
		while (n[0] == 1'b0) begin
			n = n >> 1;
			mult++;
		end
		if (mult > 0) push_factor(32'd2, mult, total, count);
		for (f = 32'd3; f <= n / f; f = f + 32'd2) begin
			mult = 0;
			while (n % f == 32'd0) begin
				n = n / f;
				mult++;
			end
			if (mult > 0) push_factor(f, mult, total, count);
		end
		if (n > 32'd1) push_factor(n, 1, total, count);
		item = expected_factors.pop_back();
		item.last = 1'b1;
		expected_factors.push_back(item);
	endfunction

	always @(posedge clk) begin
		factor_t want;
		if (arst_n) begin
			if (start && !busy) predict_factors(value);
			if (result_valid) begin
				if (expected_factors.size() == 0) begin
					$error("result with no request pending: prime %0d", prime);
					failures++;
				end else begin
					want = expected_factors.pop_front();
					if (prime !== want.prime) begin
						$error("prime: expected %0d, got %0d", want.prime, prime);
						failures++;
					end
					if (exponent !== want.exponent) begin
						$error("exponent: expected %0d, got %0d", want.exponent, exponent);
						failures++;
					end
					if (steps !== want.steps) begin
						$error("steps: expected %0d, got %0d", want.steps, steps);
						failures++;
					end
					if (running_total !== want.running_total) begin
						$error("running_total: expected %0d, got %0d", want.running_total,
							running_total);
						failures++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						failures++;
					end
				end
			end
			outstanding = expected_factors.size();
		end
	end

endmodule

FILE: bench/tb_factorize_and_count_exponent_steps.sv
// Testbench top that drives factorization requests and reports the verdict.
`timescale 1ns / 1ps

module tb_factorize_and_count_exponent_steps;
	import fces_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 20_000_000;
	localparam int RANDOM_PER_PHASE = 27;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [31:0]        value = '0;
	logic               busy;
	logic               result_valid;
	logic [PRIME_W-1:0] prime;
	logic [EXP_W-1:0]   exponent;
	logic [STEP_W-1:0]  steps;
	logic [TOTAL_W-1:0] running_total;
	logic               last;
	int                 failures;
	int                 outstanding;
	int unsigned        sender_idle = 21;
	int unsigned        cycle_count = 0;

	logic [31:0] directed_values[] = '{
		32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9,
		32'hFFFF_FFFF, 32'h8000_0000, 32'd3486784401, 32'd223092870,
		32'd65521, 32'd4293853184, 32'd4294966528, 32'd93312000,
		32'd268435456, 32'd402653184, 32'd4096012288, 32'hAAAA_AAAA,
		32'h5555_5555, 32'd14348907
	};

	always #5 clk = ~clk;

	factorize_and_count_exponent_steps dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.result_valid (result_valid),
		.prime        (prime),
		.exponent     (exponent),
		.steps        (steps),
		.running_total(running_total),
		.last         (last)
	);

	factorize_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.result_valid (result_valid),
		.prime        (prime),
		.exponent     (exponent),
		.steps        (steps),
		.running_total(running_total),
		.last         (last),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("factorize_and_count_exponent_steps: mismatch");
			$finish;
		end
	end

	// Mostly smooth numbers, so that trial division stays short even for wide values.
	function automatic logic [31:0] random_value();
		logic [63:0] acc;
		logic [63:0] factor;
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 5) return 32'($urandom_range(3));
		if (kind < 15) return 32'(($urandom_range(255) | 1) << $urandom_range(24));
		if (kind < 25) return 32'($urandom_range(65535));
		acc = 64'd1;
		if (kind < 35) begin
			factor = 64'(2 * $urandom_range(5, 1) + 1);
			while (acc * factor <= 64'hFFFF_FFFF) acc = acc * factor;
			return acc[31:0];
		end
		if (kind < 60) acc = 64'($urandom_range(65535, 2));
		factor = 64'($urandom_range(300, 2));
		while (acc * factor <= 64'hFFFF_FFFF) begin
			acc = acc * factor;
			factor = 64'($urandom_range(300, 2));
		end
		return acc[31:0];
	endfunction

	task automatic issue_request(input logic [31:0] request_value);
		while ($urandom_range(99) < sender_idle) begin
			start <= 1'b0;
			value <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		value <= request_value;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_values[i]) issue_request(directed_values[i]);
		for (int i = 0; i < RANDOM_PER_PHASE; i++) issue_request(random_value());
		sender_idle = 70;
		for (int i = 0; i < RANDOM_PER_PHASE; i++) issue_request(random_value());
		sender_idle = 0;
		for (int i = 0; i < RANDOM_PER_PHASE; i++) issue_request(random_value());
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0 || busy);
		repeat (50) @(negedge clk);
		if (failures == 0) begin
			$display("factorize_and_count_exponent_steps: match");
		end else begin
			$display("factorize_and_count_exponent_steps: mismatch");
		end
		$finish;
	end

endmodule

FILE: factorize_and_count_exponent_steps.f
+incdir+design
design/fces_pkg.sv
design/factorize_and_count_exponent_steps.sv
bench/factorize_checker.sv
bench/tb_factorize_and_count_exponent_steps.sv
